### sv/bhsp_pkg.sv
`timescale 1ns / 1ps
// Package for the bone hierarchy skin palette.
// Types, sizes and the saturation helper for fixed-point products; no dependencies.
package bhsp_pkg;
  localparam int MAX_BONES = 256;
  localparam int SKIN_SLOTS = 128;
  localparam int FRAC_BITS = 16;
  localparam int BONE_W = 8;
  localparam int ELEM_W = 32;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W = PROD_W - FRAC_BITS + 2;
  localparam int QDEPTH = 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_POSE = 1'b1;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef elem_t [15:0] mat_t;

  typedef struct packed {
    logic                 pose;
    logic [BONE_W-1:0]    bone;
    logic                 is_root;
    logic                 parent_ok;
    logic [BONE_W-1:0]    parent;
    logic                 emit;
    logic [6:0]           slot;
    mat_t                 local_m;
  } job_t;

  function automatic elem_t sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sh7FFFFFFF);
    lo = -ACC_W'(64'sh80000000);
    if (v > hi) begin
      return elem_t'(hi);
    end else if (v < lo) begin
      return elem_t'(lo);
    end
    return v[ELEM_W-1:0];
  endfunction
endpackage

### sv/bhsp_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, classifies them and queues jobs.
// Depends on bhsp_pkg.
module bhsp_front import bhsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  input  logic [7:0]        in_bone_index,
  input  logic [7:0]        in_parent_index,
  input  logic signed [7:0] in_skin_slot,
  input  logic [63:0]       in_pair_0,
  input  logic [63:0]       in_pair_1,
  input  logic [63:0]       in_pair_2,
  input  logic [63:0]       in_pair_3,
  input  logic [63:0]       in_pair_4,
  input  logic [63:0]       in_pair_5,
  input  logic [63:0]       in_pair_6,
  input  logic [63:0]       in_pair_7,
  output logic              job_valid,
  input  logic              job_take,
  output job_t              job
);
  job_t q_r [QDEPTH];
  logic [$clog2(QDEPTH+1)-1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  job_t nj;
  logic [63:0] pr [8];
  logic acc, keep;

  assign pr = '{in_pair_0, in_pair_1, in_pair_2, in_pair_3,
                in_pair_4, in_pair_5, in_pair_6, in_pair_7};
  assign in_stall = (cnt_r == QDEPTH[$clog2(QDEPTH+1)-1:0]);
  assign acc = in_valid && !in_stall;
  assign keep = 32'(in_bone_index) < MAX_BONES;

  always_comb begin
    nj.pose = (in_command == CMD_POSE);
    nj.bone = in_bone_index;
    nj.is_root = (in_bone_index == '0);
    nj.parent_ok = 32'(in_parent_index) < MAX_BONES;
    nj.parent = in_parent_index;
    nj.emit = !in_skin_slot[7] && (32'(in_skin_slot[6:0]) < SKIN_SLOTS);
    nj.slot = in_skin_slot[6:0];
    for (int k = 0; k < 8; k++) begin
      nj.local_m[2*k] = pr[k][31:0];
      nj.local_m[2*k+1] = pr[k][63:32];
    end
  end

  assign job_valid = cnt_r != '0;
  assign job = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc && keep) cnt_nxt = cnt_nxt + 1'b1;
    if (job_take) cnt_nxt = cnt_nxt - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc && keep) wp_r <= !wp_r;
      if (job_take) rp_r <= !rp_r;
    end
    if (acc && keep) q_r[wp_r] <= nj;
  end
endmodule

### sv/bhsp_back.sv
`timescale 1ns / 1ps
// Back end: matrix stores and one shared MAC unit, one result element at a time; a new job is taken only when idle.
// Depends on bhsp_pkg.
module bhsp_back import bhsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_take,
  input  job_t        job,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_slot,
  output mat_t        out_mat
);
  typedef enum logic [2:0] {S_IDLE, S_LD, S_RDP, S_MUL1, S_RDI, S_MUL2, S_OUT} st_t;
  st_t st_r;
  elem_t wst [MAX_BONES*16];
  elem_t ist [MAX_BONES*16];
  mat_t a_r, b_r, res_r, lm_r;
  job_t j_r;
  logic [3:0] idx_r;
  logic [1:0] k_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [$clog2(MAX_BONES*16)-1:0] wa_r;
  elem_t rd_r;
  logic rd_zero_r;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] accn;
  logic [1:0] rr, cc;

  assign rr = idx_r[1:0];
  assign cc = idx_r[3:2];
  assign prod = $signed(a_r[{k_r, rr}]) * $signed(b_r[{cc, k_r}]);
  assign accn = acc_r + ACC_W'(prod >>> FRAC_BITS);
  assign job_take = (st_r == S_IDLE) && job_valid;
  assign out_valid = (st_r == S_OUT);

  always_ff @(posedge clk) begin
    rd_r <= (st_r == S_RDI) ? ist[wa_r] : wst[wa_r];
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: if (job_valid) begin
          j_r <= job;
          lm_r <= job.local_m;
          idx_r <= '0;
          if (!job.pose) begin
            st_r <= S_LD;
          end else if (job.is_root) begin
            res_r <= job.local_m;
            st_r <= S_RDI;
            wa_r <= {job.bone, 4'd0};
          end else begin
            wa_r <= {job.parent, 4'd0};
            rd_zero_r <= !job.parent_ok;
            st_r <= S_RDP;
          end
        end
        S_LD: begin
          ist[{j_r.bone, idx_r}] <= lm_r[idx_r];
          idx_r <= idx_r + 1'b1;
          if (idx_r == 4'd15) st_r <= S_IDLE;
        end
        S_RDP, S_RDI: begin
          if (idx_r == 4'd15 && wa_r[3:0] == 4'd0) begin
            idx_r <= '0;
            k_r <= '0;
            acc_r <= '0;
            if (st_r == S_RDP) begin
              a_r[15] <= rd_zero_r ? '0 : rd_r;
              b_r <= lm_r;
              st_r <= S_MUL1;
            end else if (j_r.emit) begin
              b_r <= {rd_r, a_r[14:0]};
              a_r <= res_r;
              st_r <= S_MUL2;
            end else begin
              st_r <= S_IDLE;
            end
          end else begin
            if (idx_r != 4'd0 || wa_r[3:0] != 4'd0) begin
              a_r[idx_r] <= (st_r == S_RDP && rd_zero_r) ? '0 : rd_r;
              idx_r <= idx_r + 1'b1;
            end
            wa_r[3:0] <= wa_r[3:0] + 1'b1;
          end
        end
        S_MUL1, S_MUL2: begin
          k_r <= k_r + 1'b1;
          if (k_r == 2'd3) begin
            acc_r <= '0;
            res_r[idx_r] <= sat32(accn);
            if (idx_r == 4'd15) begin
              idx_r <= '0;
              if (st_r == S_MUL1) begin
                st_r <= S_RDI;
                wa_r <= {j_r.bone, 4'd0};
              end else begin
                st_r <= S_OUT;
              end
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end else begin
            acc_r <= accn;
          end
        end
        S_OUT: if (!out_stall) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
      if (st_r == S_RDI) wst[{j_r.bone, wa_r[3:0]}] <= res_r[wa_r[3:0]];
    end
  end

  assign out_slot = j_r.slot;
  assign out_mat = res_r;
endmodule

### sv/bone_hierarchy_skin_palette.sv
`timescale 1ns / 1ps
// Bone hierarchy skin palette, top level. Depends on bhsp_pkg, bhsp_front, bhsp_back.
// Load: the back end fills the inverse bind store. Pose with a result: two store
// reads and two products on one shared multiply-accumulate unit; a root skips the
// parent read and first product. Without a result, only the world store is written.
// Reset (synchronous, active low) empties the job queue and idles the back end;
// matrix stores keep their contents.
module bone_hierarchy_skin_palette import bhsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  input  logic [7:0]        in_bone_index,
  input  logic [7:0]        in_parent_index,
  input  logic signed [7:0] in_skin_slot,
  input  logic [63:0]       in_pair_0,
  input  logic [63:0]       in_pair_1,
  input  logic [63:0]       in_pair_2,
  input  logic [63:0]       in_pair_3,
  input  logic [63:0]       in_pair_4,
  input  logic [63:0]       in_pair_5,
  input  logic [63:0]       in_pair_6,
  input  logic [63:0]       in_pair_7,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [6:0]        out_slot,
  output logic [63:0]       out_pair_0,
  output logic [63:0]       out_pair_1,
  output logic [63:0]       out_pair_2,
  output logic [63:0]       out_pair_3,
  output logic [63:0]       out_pair_4,
  output logic [63:0]       out_pair_5,
  output logic [63:0]       out_pair_6,
  output logic [63:0]       out_pair_7
);
  logic jv, jt;
  job_t jb;
  mat_t m;

  bhsp_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_bone_index,
    .in_parent_index, .in_skin_slot, .in_pair_0, .in_pair_1, .in_pair_2,
    .in_pair_3, .in_pair_4, .in_pair_5, .in_pair_6, .in_pair_7,
    .job_valid(jv), .job_take(jt), .job(jb)
  );

  bhsp_back u_back (
    .clk, .rst_n, .job_valid(jv), .job_take(jt), .job(jb),
    .out_valid, .out_stall, .out_slot, .out_mat(m)
  );

  assign out_pair_0 = {m[1], m[0]};
  assign out_pair_1 = {m[3], m[2]};
  assign out_pair_2 = {m[5], m[4]};
  assign out_pair_3 = {m[7], m[6]};
  assign out_pair_4 = {m[9], m[8]};
  assign out_pair_5 = {m[11], m[10]};
  assign out_pair_6 = {m[13], m[12]};
  assign out_pair_7 = {m[15], m[14]};
endmodule

### sv/bhsp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the bone hierarchy skin palette, bound to the top level.
// Depends on bone_hierarchy_skin_palette ports only.
module bhsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [6:0]  out_slot,
  input logic [63:0] out_pair_0
);
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("stall after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_slot) && $stable(out_pair_0))
    else $error("stalled result changed");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("back to back results");
endmodule

bind bone_hierarchy_skin_palette bhsp_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_slot, .out_pair_0
);

### tb/bhsp_skin_checker.sv
`timescale 1ns / 1ps
// Checker for the bone hierarchy skin palette: predicts skinning matrices from
// accepted requests and compares them with accepted results. Depends on bhsp_pkg.
module bhsp_skin_checker import bhsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_command,
  input  logic [7:0]        in_bone_index,
  input  logic [7:0]        in_parent_index,
  input  logic signed [7:0] in_skin_slot,
  input  logic [7:0][63:0]  in_pairs,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [6:0]        out_slot,
  input  logic [7:0][63:0]  out_pairs,
  output int                errors,
  output int                pending
);
  typedef struct packed {
    logic [6:0]       slot;
    logic [7:0][63:0] pairs;
  } skin_t;

  mat_t  world_mats [MAX_BONES];
  mat_t  inv_bind_mats [MAX_BONES];
  skin_t skin_q [$];

  function automatic mat_t unpack_pairs(logic [7:0][63:0] p);
    mat_t m;
    for (int k = 0; k < 8; k++) begin
      m[2*k] = p[k][31:0];
      m[2*k+1] = p[k][63:32];
    end
    return m;
  endfunction

  function automatic mat_t mat_product(mat_t a, mat_t b);
    mat_t   res;
    longint acc;
    longint prod;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) begin
          prod = longint'($signed(a[k*4+r])) * longint'($signed(b[c*4+k]));
          acc += prod >>> FRAC_BITS;
        end
        if (acc > 64'sh7FFFFFFF) acc = 64'sh7FFFFFFF;
        if (acc < -64'sh80000000) acc = -64'sh80000000;
        res[c*4+r] = acc[31:0];
      end
    end
    return res;
  endfunction

  task automatic predict_request();
    mat_t  local_m;
    mat_t  world_m;
    mat_t  skin_m;
    skin_t exp_skin;
    local_m = unpack_pairs(in_pairs);
    if (in_command == CMD_LOAD) begin
      inv_bind_mats[in_bone_index] = local_m;
      return;
    end
    if (in_bone_index == 0) world_m = local_m;
    else world_m = mat_product(world_mats[in_parent_index], local_m);
    world_mats[in_bone_index] = world_m;
    if (in_skin_slot < 0 || in_skin_slot >= SKIN_SLOTS) return;
    skin_m = mat_product(world_m, inv_bind_mats[in_bone_index]);
    exp_skin.slot = in_skin_slot[6:0];
    for (int k = 0; k < 8; k++) exp_skin.pairs[k] = {skin_m[2*k+1], skin_m[2*k]};
    skin_q.push_back(exp_skin);
  endtask

  task automatic report(string what, logic [63:0] exp_v, logic [63:0] act_v);
    errors++;
    if (errors <= 10)
      $display("%0t: mismatch %s expected %h actual %h", $realtime, what, exp_v, act_v);
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    skin_t exp_skin;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_request();
      if (out_valid && !out_stall) begin
        if (skin_q.size() == 0) begin
          report("unexpected result slot", 64'd0, 64'(out_slot));
        end else begin
          exp_skin = skin_q.pop_front();
          if (out_slot !== exp_skin.slot)
            report("slot", 64'(exp_skin.slot), 64'(out_slot));
          for (int k = 0; k < 8; k++)
            if (out_pairs[k] !== exp_skin.pairs[k])
              report($sformatf("pair_%0d", k), exp_skin.pairs[k], out_pairs[k]);
        end
      end
    end
    pending = skin_q.size();
  end
endmodule

### tb/bone_hierarchy_skin_palette_tb.sv
`timescale 1ns / 1ps
// Top of the bone hierarchy skin palette testbench: clock, reset and request
// stimulus. Depends on bhsp_pkg, bone_hierarchy_skin_palette, bhsp_skin_checker.
module bone_hierarchy_skin_palette_tb;
  import bhsp_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_command;
  logic [7:0]        in_bone_index;
  logic [7:0]        in_parent_index;
  logic signed [7:0] in_skin_slot;
  logic [7:0][63:0]  in_pairs;
  logic              out_valid;
  logic              out_stall;
  logic [6:0]        out_slot;
  logic [7:0][63:0]  out_pairs;
  int                errors;
  int                pending;

  bit gaps_on;
  bit loaded [MAX_BONES];
  bit posed [MAX_BONES];
  int posed_q [$];

  bone_hierarchy_skin_palette i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_bone_index(in_bone_index), .in_parent_index(in_parent_index),
    .in_skin_slot(in_skin_slot),
    .in_pair_0(in_pairs[0]), .in_pair_1(in_pairs[1]), .in_pair_2(in_pairs[2]),
    .in_pair_3(in_pairs[3]), .in_pair_4(in_pairs[4]), .in_pair_5(in_pairs[5]),
    .in_pair_6(in_pairs[6]), .in_pair_7(in_pairs[7]),
    .out_valid(out_valid), .out_stall(out_stall), .out_slot(out_slot),
    .out_pair_0(out_pairs[0]), .out_pair_1(out_pairs[1]), .out_pair_2(out_pairs[2]),
    .out_pair_3(out_pairs[3]), .out_pair_4(out_pairs[4]), .out_pair_5(out_pairs[5]),
    .out_pair_6(out_pairs[6]), .out_pair_7(out_pairs[7])
  );

  bhsp_skin_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_bone_index(in_bone_index), .in_parent_index(in_parent_index),
    .in_skin_slot(in_skin_slot), .in_pairs(in_pairs),
    .out_valid(out_valid), .out_stall(out_stall), .out_slot(out_slot),
    .out_pairs(out_pairs), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #24_000_000;
    $display("bone_hierarchy_skin_palette verification failed");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  function automatic logic [31:0] pick_word(int kind);
    logic [31:0] edge_words [5] = '{32'h7FFFFFFF, 32'h80000000, 32'h0,
                                    32'h00010000, 32'hFFFFFFFF};
    case (kind)
      0: begin
        return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      end
      1: begin
        return $urandom;
      end
      default: begin
        return edge_words[$urandom_range(0, 4)];
      end
    endcase
  endfunction

  function automatic logic [7:0][63:0] make_matrix(int kind);
    logic [7:0][63:0] p;
    for (int k = 0; k < 8; k++) p[k] = {pick_word(kind), pick_word(kind)};
    return p;
  endfunction

  function automatic logic [7:0][63:0] identity_matrix();
    logic [7:0][63:0] p;
    p = '0;
    p[0][31:0] = 32'h00010000;
    p[2][63:32] = 32'h00010000;
    p[5][31:0] = 32'h00010000;
    p[7][63:32] = 32'h00010000;
    return p;
  endfunction

  task automatic send_request(logic cmd, logic [7:0] bone, logic [7:0] parent,
                              logic signed [7:0] slot, logic [7:0][63:0] pairs);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_command = cmd;
    in_bone_index = bone;
    in_parent_index = parent;
    in_skin_slot = slot;
    in_pairs = pairs;
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_LOAD) begin
      loaded[bone] = 1'b1;
    end else if (!posed[bone]) begin
      posed[bone] = 1'b1;
      posed_q.push_back(int'(bone));
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  initial begin
    logic [7:0]        bone;
    logic [7:0]        parent;
    logic signed [7:0] slot;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_LOAD;
    in_bone_index = '0;
    in_parent_index = '0;
    in_skin_slot = '0;
    in_pairs = '0;
    gaps_on = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    send_request(CMD_LOAD, 8'd0, 8'd0, -8'sd1, identity_matrix());
    send_request(CMD_LOAD, 8'd1, 8'd0, -8'sd1, make_matrix(2));
    send_request(CMD_LOAD, 8'd255, 8'd0, -8'sd1, make_matrix(1));
    send_request(CMD_LOAD, 8'd2, 8'd0, -8'sd1, make_matrix(0));
    send_request(CMD_POSE, 8'd0, 8'd0, 8'sd0, identity_matrix());
    send_request(CMD_POSE, 8'd1, 8'd0, 8'sd127, make_matrix(2));
    send_request(CMD_POSE, 8'd255, 8'd1, 8'sd5, make_matrix(1));
    send_request(CMD_POSE, 8'd2, 8'd255, -8'sd1, make_matrix(0));
    send_request(CMD_POSE, 8'd2, 8'd2, -8'sd128, make_matrix(0));
    send_request(CMD_POSE, 8'd2, 8'd1, 8'sd64, make_matrix(0));
    send_request(CMD_POSE, 8'd0, 8'd255, 8'sd1, make_matrix(2));
    send_request(CMD_POSE, 8'd1, 8'd2, 8'sd3, make_matrix(1));
    send_request(CMD_POSE, 8'd1, 8'd255, 8'sd126, make_matrix(2));

    gaps_on = 1'b1;
    for (int i = 0; i < 1750; i++) begin
      if (i == 1550) gaps_on = 1'b0;
      bone = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 4) == 0) begin
        send_request(CMD_LOAD, bone, 8'($urandom), 8'($urandom),
                     make_matrix($urandom_range(0, 2)));
      end else begin
        if ($urandom_range(0, 9) == 0) bone = 8'd0;
        parent = 8'($urandom);
        if (bone != 0) parent = 8'(posed_q[$urandom_range(0, posed_q.size() - 1)]);
        if (loaded[bone] && $urandom_range(0, 9) < 7) slot = 8'($urandom_range(0, 127));
        else slot = -8'sd1 - 8'($urandom_range(0, 127));
        send_request(CMD_POSE, bone, parent, slot, make_matrix($urandom_range(0, 2)));
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("bone_hierarchy_skin_palette verification clean");
    end else begin
      $display("bone_hierarchy_skin_palette verification failed");
    end
    $finish;
  end
endmodule

### files.f
sv/bhsp_pkg.sv
sv/bhsp_front.sv
sv/bhsp_back.sv
sv/bone_hierarchy_skin_palette.sv
sv/bhsp_checker.sv
tb/bhsp_skin_checker.sv
tb/bone_hierarchy_skin_palette_tb.sv
